// ===== hdl/dlr_pkg.sv =====
// ============================================================================
// dlr_pkg - shared definitions for the DDA line rasterizer
// Default sizes, the item kind code and the step engine state type.
// ============================================================================
package dlr_pkg;

    // Default coordinate width, fraction width and command queue depth.
    localparam int COORD_BITS_DEF  = 10;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Kind of an input beat, carried on s_tuser.
    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

    // Step engine states.
    typedef enum logic {
        BK_RUN    = 1'b0,
        BK_DIVIDE = 1'b1
    } back_state_t;

endpackage

// ===== hdl/dlr_front.sv =====
// ============================================================================
// dlr_front - input stage of the line rasterizer
// Accepts input beats and turns start beats into line commands: absolute
// deltas, direction signs and the step count.
// ============================================================================
module dlr_front
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int CMD_W     = 3 + 5 * COORD_BITS
) (
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [4*COORD_BITS-1:0] s_coords,   // x_start, y_start, x_end, y_end
    input  logic                    s_tuser,    // kind
    output logic                    push_valid,
    input  logic                    push_ready,
    output logic [CMD_W-1:0]        push_data
);

    typedef struct packed {
        kind_t                  kind;
        logic                   neg_x;
        logic                   neg_y;
        logic [COORD_BITS-1:0]  x_start;
        logic [COORD_BITS-1:0]  y_start;
        logic [COORD_BITS-1:0]  mag_x;
        logic [COORD_BITS-1:0]  mag_y;
        logic [COORD_BITS-1:0]  steps;
    } cmd_t;

    logic [COORD_BITS-1:0] xs, ys, xe, ye;
    logic [COORD_BITS-1:0] mag_x, mag_y;
    logic                  neg_x, neg_y;
    cmd_t                  cmd;

    assign xs = s_coords[COORD_BITS-1:0];
    assign ys = s_coords[2*COORD_BITS-1:COORD_BITS];
    assign xe = s_coords[3*COORD_BITS-1:2*COORD_BITS];
    assign ye = s_coords[4*COORD_BITS-1:3*COORD_BITS];

    assign neg_x = xe < xs;
    assign neg_y = ye < ys;
    assign mag_x = neg_x ? (xs - xe) : (xe - xs);
    assign mag_y = neg_y ? (ys - ye) : (ye - ys);

    always_comb begin
        cmd.kind    = kind_t'(s_tuser);
        cmd.neg_x   = neg_x;
        cmd.neg_y   = neg_y;
        cmd.x_start = xs;
        cmd.y_start = ys;
        cmd.mag_x   = mag_x;
        cmd.mag_y   = mag_y;
        cmd.steps   = (mag_x > mag_y) ? mag_x : mag_y;
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;
    assign push_data  = cmd;

endmodule

// ===== hdl/dlr_queue.sv =====
// ============================================================================
// dlr_queue - command queue between the input stage and the step engine
// A small register queue with a fill count.
// ============================================================================
module dlr_queue
    import dlr_pkg::*;
#(
    parameter int WIDTH = 3 + 5 * COORD_BITS_DEF,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== hdl/dlr_div.sv =====
// ============================================================================
// dlr_div - increment divider for the line rasterizer
// Two restoring dividers sharing one counter, one quotient bit per cycle,
// giving sign * floor((mag << FRAC_BITS) / steps) for x and y.
// ============================================================================
module dlr_div
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int ACC_W     = COORD_BITS + FRAC_BITS + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] mag_x,
    input  logic [COORD_BITS-1:0] mag_y,
    input  logic                  neg_x,
    input  logic                  neg_y,
    input  logic [COORD_BITS-1:0] steps,
    output logic                  done,
    output logic [ACC_W-1:0]      inc_x,
    output logic [ACC_W-1:0]      inc_y
);

    localparam int QW = FRAC_BITS + 1;
    localparam int RW = COORD_BITS + 1;
    localparam int CW = $clog2(FRAC_BITS + 1);

    logic [RW-1:0]         rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [QW-1:0]         quo_x_reg, quo_x_next, quo_y_reg, quo_y_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  neg_x_reg, neg_y_reg;
    logic [COORD_BITS-1:0] den_reg;
    logic                  ge_x, ge_y;
    logic [RW-1:0]         sub_x, sub_y, sel_x, sel_y;
    logic [ACC_W-1:0]      ext_x, ext_y;

    // The remainder stays below twice the divisor, so one compare and
    // subtract per quotient bit is enough.
    assign ge_x  = rem_x_reg >= {1'b0, den_reg};
    assign ge_y  = rem_y_reg >= {1'b0, den_reg};
    assign sub_x = rem_x_reg - {1'b0, den_reg};
    assign sub_y = rem_y_reg - {1'b0, den_reg};
    assign sel_x = ge_x ? sub_x : rem_x_reg;
    assign sel_y = ge_y ? sub_y : rem_y_reg;

    always_comb begin
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        quo_x_next = quo_x_reg;
        quo_y_next = quo_y_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            rem_x_next = {1'b0, mag_x};
            rem_y_next = {1'b0, mag_y};
            quo_x_next = '0;
            quo_y_next = '0;
            cnt_next   = CW'(FRAC_BITS);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rem_x_next = {sel_x[COORD_BITS-1:0], 1'b0};
            rem_y_next = {sel_y[COORD_BITS-1:0], 1'b0};
            quo_x_next = {quo_x_reg[QW-2:0], ge_x};
            quo_y_next = {quo_y_reg[QW-2:0], ge_y};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        quo_x_reg <= quo_x_next;
        quo_y_reg <= quo_y_next;
        cnt_reg   <= cnt_next;
        if (start) begin
            neg_x_reg <= neg_x;
            neg_y_reg <= neg_y;
            den_reg   <= steps;
        end
    end

    assign ext_x = {{(ACC_W - QW){1'b0}}, quo_x_reg};
    assign ext_y = {{(ACC_W - QW){1'b0}}, quo_y_reg};
    assign inc_x = neg_x_reg ? (ACC_W'(0) - ext_x) : ext_x;
    assign inc_y = neg_y_reg ? (ACC_W'(0) - ext_y) : ext_y;
    assign done  = done_reg;

endmodule

// ===== hdl/dlr_back.sv =====
// ============================================================================
// dlr_back - step engine of the line rasterizer
// Pops commands, holds the accumulators and increments, runs the divider on
// line setup and drives the registered output beat.
// ============================================================================
module dlr_back
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int CMD_W     = 3 + 5 * COORD_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [CMD_W-1:0]      q_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  pixel_valid,
    output logic                  is_last
);

    localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;

    typedef struct packed {
        kind_t                  kind;
        logic                   neg_x;
        logic                   neg_y;
        logic [COORD_BITS-1:0]  x_start;
        logic [COORD_BITS-1:0]  y_start;
        logic [COORD_BITS-1:0]  mag_x;
        logic [COORD_BITS-1:0]  mag_y;
        logic [COORD_BITS-1:0]  steps;
    } cmd_t;

    back_state_t           state_reg, state_next;
    cmd_t                  cmd;
    logic                  out_free, pop, div_start, div_done, long_line;
    logic [ACC_W-1:0]      div_inc_x, div_inc_y;

    // Accumulators carry a built-in half LSB so the pixel is a plain slice.
    logic [ACC_W-1:0]      acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic [ACC_W-1:0]      inc_x_reg, inc_x_next, inc_y_reg, inc_y_next;
    logic [ACC_W-1:0]      sum_x, sum_y;
    logic [COORD_BITS-1:0] left_reg, left_next;
    logic                  active_reg, active_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic                  pv_reg, pv_next, last_reg, last_next;

    assign cmd       = cmd_t'(q_data);
    assign out_free  = !out_valid_reg || m_tready;
    assign long_line = cmd.steps != '0;
    assign sum_x     = acc_x_reg + inc_x_reg;
    assign sum_y     = acc_y_reg + inc_y_reg;

    dlr_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag_x   (cmd.mag_x),
        .mag_y   (cmd.mag_y),
        .neg_x   (cmd.neg_x),
        .neg_y   (cmd.neg_y),
        .steps   (cmd.steps),
        .done    (div_done),
        .inc_x   (div_inc_x),
        .inc_y   (div_inc_y)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN: begin
                if (pop && (cmd.kind == KIND_START) && long_line) begin
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE: begin
                if (div_done) begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    // State outputs.
    always_comb begin
        pop       = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            BK_RUN: begin
                pop       = q_valid && out_free;
                div_start = pop && (cmd.kind == KIND_START) && long_line;
            end
            BK_DIVIDE: begin
                pop       = 1'b0;
                div_start = 1'b0;
            end
            default: begin
                pop       = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // Datapath.
    always_comb begin
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        inc_x_next     = inc_x_reg;
        inc_y_next     = inc_y_reg;
        left_next      = left_reg;
        active_next    = active_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pv_next        = pv_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (div_done) begin
            inc_x_next = div_inc_x;
            inc_y_next = div_inc_y;
        end
        if (pop) begin
            out_valid_next = 1'b1;
            unique case (cmd.kind)
                KIND_START: begin
                    acc_x_next  = {1'b0, cmd.x_start, 1'b1, {(FRAC_BITS - 1){1'b0}}};
                    acc_y_next  = {1'b0, cmd.y_start, 1'b1, {(FRAC_BITS - 1){1'b0}}};
                    inc_x_next  = '0;
                    inc_y_next  = '0;
                    left_next   = cmd.steps;
                    active_next = long_line;
                    px_next     = cmd.x_start;
                    py_next     = cmd.y_start;
                    pv_next     = 1'b1;
                    last_next   = !long_line;
                end
                KIND_STEP: begin
                    if (active_reg) begin
                        acc_x_next  = sum_x;
                        acc_y_next  = sum_y;
                        left_next   = left_reg - COORD_BITS'(1);
                        active_next = left_reg != COORD_BITS'(1);
                        px_next     = sum_x[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
                        py_next     = sum_y[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
                        pv_next     = 1'b1;
                        last_next   = left_reg == COORD_BITS'(1);
                    end else begin
                        px_next   = '0;
                        py_next   = '0;
                        pv_next   = 1'b0;
                        last_next = 1'b0;
                    end
                end
                default: begin
                    pv_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_RUN;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            inc_x_reg     <= '0;
            inc_y_reg     <= '0;
            left_reg      <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            inc_x_reg     <= inc_x_next;
            inc_y_reg     <= inc_y_next;
            left_reg      <= left_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pv_reg   <= pv_next;
        last_reg <= last_next;
    end

    assign q_ready     = pop;
    assign m_tvalid    = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_valid = pv_reg;
    assign is_last     = last_reg;

endmodule

// ===== hdl/dda_line_rasterizer_unit.sv =====
// ============================================================================
// dda_line_rasterizer_unit - DDA line rasterizer, top level
// Turns start and step beats into one pixel beat each, walking a line in
// fixed point from its start point to its end point.
// ============================================================================
// Send a start beat (s_tuser low) with both endpoints to begin a line; it
// returns the start pixel at once. Each step beat (s_tuser high) then returns
// the next pixel, and the pixel that reaches the end of the line comes with
// m_tlast high. A step beat with no line in progress returns a beat with
// m_tuser low and zero data. Equal endpoints give a single pixel with m_tlast
// high. Every input beat gives exactly one output beat, in order. Step beats
// flow at one per clock unless stalled by the receiver or a division. A start
// beat with distinct endpoints holds the step engine while the divider forms
// the x and y increments one quotient bit per clock; meanwhile the input side
// keeps taking beats into a QUEUE_DEPTH entry command queue. Coordinates step
// in signed fixed point with FRAC_BITS fraction bits, increments truncated
// toward zero, and every pixel is the accumulator rounded half up, so the
// last pixel may fall short of the end point when FRAC_BITS is small.
// ============================================================================
module dda_line_rasterizer_unit
    import dlr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int S_DATA_W   = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Input beats.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // x_start, y_start, x_end, y_end, zero fill
    input  logic                s_tuser,   // kind: low starts a line, high steps
    // Pixel beats.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // pixel_x, pixel_y, zero fill
    output logic                m_tuser,   // pixel_valid
    output logic                m_tlast    // is_last
);

    localparam int CMD_W = 3 + 5 * COORD_BITS;

    logic                  push_valid, push_ready;
    logic [CMD_W-1:0]      push_data;
    logic                  q_valid, q_ready;
    logic [CMD_W-1:0]      q_data;
    logic [COORD_BITS-1:0] pixel_x, pixel_y;

    // The input stage classifies each beat and precomputes the line deltas.
    dlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_coords   (s_tdata[4*COORD_BITS-1:0]),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // The queue lets the input side keep accepting while the engine divides.
    dlr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // The step engine owns all line state and the registered output beat.
    dlr_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_valid (m_tuser),
        .is_last     (m_tlast)
    );

    assign m_tdata = M_DATA_W'({pixel_y, pixel_x});

    // A beat without a pixel never ends a line.
    a_no_pixel_no_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> !m_tlast
    ) else $error("beat without a pixel carries tlast");

    // A beat without a pixel carries zero coordinates.
    a_no_pixel_zero_data: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0)
    ) else $error("beat without a pixel carries nonzero data");

    // Back-pressure on the input only comes from a queue holding commands.
    a_stall_means_queued: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid
    ) else $error("input stalled with an empty command queue");

endmodule

// ===== tb/dda_line_rasterizer_unit_tb.sv =====
// ============================================================================
// dda_line_rasterizer_unit_tb - self-checking bench for the DDA line rasterizer
// Drives start and step beats with random gaps on both sides. A scoreboard
// walks each line in fixed point and predicts every pixel beat, then compares
// the pixel beats that come back in order, field by field.
// ============================================================================
module dda_line_rasterizer_unit_tb;
    import dlr_pkg::*;

    localparam int CB    = COORD_BITS_DEF;
    localparam int FB    = FRAC_BITS_DEF;
    localparam int S_W   = ((4 * CB + 7) / 8) * 8;
    localparam int M_W   = ((2 * CB + 7) / 8) * 8;
    localparam int CMAX  = (1 << CB) - 1;
    // Divider hold-off plus the command queue, with some margin.
    localparam int DRAIN = FB + 3 + QUEUE_DEPTH_DEF + 16;

    // One predicted pixel beat.
    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          valid;
        logic          last;
    } pixel_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a line walker of its own plus the queue of pixels that the
    // block still owes us.
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        bit [63:0] pos_x, pos_y;     // accumulators, two's complement
        bit [63:0] inc_x, inc_y;     // per-step increments
        bit [63:0] steps_left;
        bit        drawing;
        pixel_t    pending_pixels[$];
        int        errors;
        int        pixels_seen;

        function new();
            pos_x = 0;
            pos_y = 0;
            inc_x = 0;
            inc_y = 0;
            steps_left = 0;
            drawing = 0;
            errors = 0;
            pixels_seen = 0;
        endfunction

        // Signed increment, magnitude truncated toward zero.
        function bit [63:0] slope(bit [63:0] from, bit [63:0] to, bit [63:0] span);
            bit [63:0] mag;
            if (to < from) begin
                mag = ((from - to) << FB) / span;
                return 64'd0 - mag;
            end
            mag = ((to - from) << FB) / span;
            return mag;
        endfunction

        // Round half up; the low bits of a logical shift match a floor shift.
        function logic [CB-1:0] snap(bit [63:0] v);
            bit [63:0] r;
            r = (v + (64'd1 << (FB - 1))) >> FB;
            return r[CB-1:0];
        endfunction

        function void note_beat(kind_t k, logic [S_W-1:0] d);
            bit [63:0] xs, ys, xe, ye, adx, ady, span;
            pixel_t    px;
            xs = d[CB-1:0];
            ys = d[2*CB-1:CB];
            xe = d[3*CB-1:2*CB];
            ye = d[4*CB-1:3*CB];
            px = '0;
            if (k == KIND_START) begin
                adx = (xe >= xs) ? xe - xs : xs - xe;
                ady = (ye >= ys) ? ye - ys : ys - ye;
                span = (adx > ady) ? adx : ady;
                pos_x = xs << FB;
                pos_y = ys << FB;
                px.x = xs[CB-1:0];
                px.y = ys[CB-1:0];
                px.valid = 1'b1;
                if (span == 0) begin
                    // Degenerate line: one pixel, nothing to divide.
                    inc_x = 0;
                    inc_y = 0;
                    steps_left = 0;
                    drawing = 1'b0;
                    px.last = 1'b1;
                end else begin
                    inc_x = slope(xs, xe, span);
                    inc_y = slope(ys, ye, span);
                    steps_left = span;
                    drawing = 1'b1;
                end
            end else if (drawing) begin
                pos_x = pos_x + inc_x;
                pos_y = pos_y + inc_y;
                steps_left = steps_left - 1;
                px.x = snap(pos_x);
                px.y = snap(pos_y);
                px.valid = 1'b1;
                if (steps_left == 0) begin
                    drawing = 1'b0;
                    px.last = 1'b1;
                end
            end
            pending_pixels.push_back(px);
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR pixel %0d: %s", pixels_seen, msg);
        endtask

        task check_pixel(logic [M_W-1:0] data, logic user, logic last);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                report($sformatf("unexpected beat data=%h user=%b last=%b",
                                 data, user, last));
            end else begin
                want = pending_pixels.pop_front();
                if (data[CB-1:0] !== want.x)
                    report($sformatf("pixel_x %0d, expected %0d", data[CB-1:0], want.x));
                if (data[2*CB-1:CB] !== want.y)
                    report($sformatf("pixel_y %0d, expected %0d", data[2*CB-1:CB], want.y));
                if ((data >> (2 * CB)) !== 0)
                    report($sformatf("nonzero fill bits in m_tdata %h", data));
                if (user !== want.valid)
                    report($sformatf("pixel_valid %b, expected %b", user, want.valid));
                if (last !== want.last)
                    report($sformatf("is_last %b, expected %b", last, want.last));
            end
            pixels_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test.
    // ------------------------------------------------------------------------
    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;       // x_start, y_start, x_end, y_end
    logic           s_tuser;       // kind
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;       // pixel_x, pixel_y, zero fill
    logic           m_tuser;       // pixel_valid
    logic           m_tlast;       // is_last

    pixel_scoreboard sb;
    bit              calm = 1'b0;  // when set, neither side idles
    int              beats_sent = 0;

    dda_line_rasterizer_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // The receiver decides its ready at each falling edge, so stalls land on
    // every phase of the line walk, the divider hold-off included.
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 27);
    end

    // Every pixel beat that the block hands over is checked at the edge
    // where the handshake completes.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tuser, m_tlast);
    end

    // ------------------------------------------------------------------------
    // Sender tasks. They are entered just after a falling edge and return
    // just after one, leaving s_tvalid high so that back-to-back beats do not
    // drop valid in between.
    // ------------------------------------------------------------------------
    task send_beat(kind_t k, logic [S_W-1:0] d);
        while (!calm && $urandom_range(0, 99) < 27) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(k, d);
        beats_sent++;
        @(negedge aclk);
    endtask

    // A step beat carries random data, which the block must ignore.
    task step_beat();
        logic [S_W-1:0] junk;
        junk = S_W'({$urandom, $urandom});
        send_beat(KIND_STEP, junk);
    endtask

    // One start beat followed by n step beats. An n below the line length
    // leaves the line to be dropped by the next start; an n above it runs
    // into steps with no line in progress.
    task draw(int xs, int ys, int xe, int ye, int n);
        logic [S_W-1:0] d;
        d = '0;
        d[CB-1:0]      = xs[CB-1:0];
        d[2*CB-1:CB]   = ys[CB-1:0];
        d[3*CB-1:2*CB] = xe[CB-1:0];
        d[4*CB-1:3*CB] = ye[CB-1:0];
        send_beat(KIND_START, d);
        repeat (n) step_beat();
    endtask

    task drain_wait();
        while (sb.pending_pixels.size() != 0) @(negedge aclk);
    endtask

    function int near(int c);
        int v;
        v = c + $urandom_range(0, 32) - 16;
        if (v < 0) v = 0;
        if (v > CMAX) v = CMAX;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int  xs, ys, xe, ye, span, n, r;
        bit  paused;
        sb = new();
        paused   = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_START;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. A step right after reset finds no line.
        step_beat();
        // Equal endpoints, then a step that again finds no line.
        draw(5, 5, 5, 5, 1);
        // Shallow line walked to its end and one step past it.
        draw(0, 0, 3, 1, 4);
        // Both coordinates counting down from the top corner.
        draw(CMAX, CMAX, CMAX - 3, CMAX - 1, 3);
        // A line that is cut short by the next start.
        draw(10, 10, 20, 30, 1);
        draw(CMAX, 0, CMAX - 2, 3, 3);
        // Vertical line.
        draw(7, 0, 7, 2, 2);
        // Degenerate lines at the corners.
        draw(0, CMAX, 0, CMAX, 0);
        draw(CMAX, 0, CMAX, 0, 0);

        // Hold the sender until the block has caught up.
        s_tvalid <= 1'b0;
        @(negedge aclk);
        drain_wait();

        // One line across the full width, walked to its end, so that the
        // accumulated truncation error over the longest line is checked.
        draw(0, $urandom_range(0, CMAX), CMAX, $urandom_range(0, CMAX), CMAX + 1);

        while (beats_sent < 1750) begin
            calm = (beats_sent >= 1100 && beats_sent < 1300);
            if (!paused && beats_sent >= 1400) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                @(negedge aclk);
                drain_wait();
            end
            r = $urandom_range(0, 99);
            if (r < 5) begin
                // Noise: stray steps, mostly with no line in progress.
                repeat ($urandom_range(1, 3)) step_beat();
            end else begin
                xs = $urandom_range(0, CMAX);
                ys = $urandom_range(0, CMAX);
                if (r < 15) begin
                    xe = $urandom_range(0, CMAX);
                    ye = $urandom_range(0, CMAX);
                end else begin
                    xe = near(xs);
                    ye = near(ys);
                end
                span = (xe > xs) ? xe - xs : xs - xe;
                if (((ye > ys) ? ye - ys : ys - ye) > span)
                    span = (ye > ys) ? ye - ys : ys - ye;
                r = $urandom_range(0, 99);
                if (span > 40)
                    n = $urandom_range(0, 12);          // long lines are cut short
                else if (r < 70 || span == 0)
                    n = span;
                else if (r < 85)
                    n = span + $urandom_range(1, 3);
                else
                    n = $urandom_range(0, span - 1);
                draw(xs, ys, xe, ye, n);
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Let every owed pixel arrive, then watch for strays a while longer.
        drain_wait();
        repeat (DRAIN) @(negedge aclk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
